// ----- hw/rtl/gemp_pkg.sv -----
// Shared types and constants for the greedy error-mask projection block.
package gemp_pkg;

    localparam int unsigned DATA_W = 64;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_GET_I,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/greedy_error_mask_projection_core.sv -----
// Top level of the greedy error-mask projection block.
// Rows are loaded one per cycle into a row memory. When the row flagged last is taken,
// the block stops accepting input and a sequencer walks the stored rows in load order
// over the single read port of that memory. Each stored row is fetched and tested in
// turn, and every flagged nonzero row adds a subset scan over all N stored rows before
// the sequencer moves on; the result is registered once the last row is done. Rows
// beyond MAX_ROWS are dropped and reported in the result. A new set may start loading
// while the previous result still waits to be taken.
module greedy_error_mask_projection_core #(
    parameter int MAX_ROWS = 64,
    parameter int ROW_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [gemp_pkg::DATA_W-1:0] i_s_tdata,   // [63:0] row_bits
    input  logic                        i_s_tuser,   // [0] row_is_error
    input  logic                        i_s_tlast,   // last_row
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [gemp_pkg::DATA_W-1:0] o_m_tdata,   // [63:0] mask_bits
    output logic                        o_m_tuser    // [0] rows_dropped
);
    import gemp_pkg::*;

    localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int MEM_W  = ROW_BITS + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ROWS);

    t_state r_state, n_state;

    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic [CNT_W-1:0]    r_rows, n_rows;
    logic [CNT_W-1:0]    r_i, n_i;
    logic [CNT_W-1:0]    r_j, n_j;
    logic                r_pend, n_pend;
    logic                r_hit, n_hit;
    logic [ROW_BITS-1:0] r_mask, n_mask;
    logic [ROW_BITS-1:0] r_cand, n_cand;
    logic                r_out_valid, n_out_valid;
    logic [ROW_BITS-1:0] r_out_mask, n_out_mask;
    logic                r_out_drop, n_out_drop;

    logic                s_fire;
    logic                out_free;
    logic                scan_end;
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [MEM_W-1:0]    ram_wdata;
    logic [MEM_W-1:0]    ram_rdata;
    logic                rd_err;
    logic [ROW_BITS-1:0] rd_row;
    logic                rd_clean_sub;
    logic [DATA_W-1:0]   out_data;

    assign s_fire   = i_s_tvalid & o_s_tready;
    assign out_free = ~r_out_valid | i_m_tready;
    assign scan_end = (r_j == r_rows) & ~r_pend;
    assign rd_err   = ram_rdata[ROW_BITS];
    assign rd_row   = ram_rdata[ROW_BITS-1:0];
    assign rd_clean_sub = ~rd_err & (rd_row != '0) & ((rd_row & ~r_cand) == '0);
    assign ram_wdata = {i_s_tuser, i_s_tdata[ROW_BITS-1:0]};

    gemp_ram #(
        .WIDTH(MEM_W),
        .DEPTH(MAX_ROWS)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[ADDR_W-1:0]),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (s_fire && i_s_tlast) begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I: begin
                n_state = (r_i == r_rows) ? ST_DONE : ST_GET_I;
            end
            ST_GET_I: begin
                n_state = (rd_err && rd_row != '0) ? ST_SCAN : ST_RD_I;
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_RD_I;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_s_tready  = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_i[ADDR_W-1:0];
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_rows      = r_rows;
        n_i         = r_i;
        n_j         = r_j;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_mask      = r_mask;
        n_cand      = r_cand;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_out_mask  = r_out_mask;
        n_out_drop  = r_out_drop;
        unique case (r_state)
            ST_LOAD: begin
                o_s_tready = 1'b1;
                if (s_fire) begin
                    if (r_count < MAX_CNT) begin
                        ram_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_rows = (r_count < MAX_CNT) ? r_count + CNT_W'(1) : r_count;
                        n_i    = '0;
                        n_mask = '0;
                    end
                end
            end
            ST_RD_I: begin
                ram_re    = (r_i != r_rows);
                ram_raddr = r_i[ADDR_W-1:0];
            end
            ST_GET_I: begin
                if (rd_err && rd_row != '0) begin
                    n_cand = r_mask | rd_row;
                    n_j    = '0;
                    n_pend = 1'b0;
                    n_hit  = 1'b0;
                end else begin
                    n_i = r_i + CNT_W'(1);
                end
            end
            ST_SCAN: begin
                ram_raddr = r_j[ADDR_W-1:0];
                ram_re    = (r_j != r_rows);
                n_pend    = (r_j != r_rows);
                if (r_j != r_rows) begin
                    n_j = r_j + CNT_W'(1);
                end
                if (r_pend && rd_clean_sub) begin
                    n_hit = 1'b1;
                end
                if (scan_end) begin
                    n_mask = r_hit ? r_mask : r_cand;
                    n_i    = r_i + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_mask  = r_mask;
                    n_out_drop  = r_ovf;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_mask      = '0;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_mask      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_mask      <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows     <= n_rows;
        r_i        <= n_i;
        r_j        <= n_j;
        r_pend     <= n_pend;
        r_hit      <= n_hit;
        r_cand     <= n_cand;
        r_out_mask <= n_out_mask;
        r_out_drop <= n_out_drop;
    end

    always_comb begin
        out_data = '0;
        out_data[ROW_BITS-1:0] = r_out_mask;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = out_data;
    assign o_m_tuser  = r_out_drop;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("row count beyond store depth");

    a_rows_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> (r_rows != '0 && r_rows <= MAX_CNT))
        else $error("compute started with bad row total");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> (r_i <= r_rows))
        else $error("outer index past row total");

    a_cand_covers_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_mask & ~r_cand) == '0))
        else $error("candidate lost mask bits");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_count == '0 && !r_ovf && o_m_tvalid))
        else $error("store not cleared after result");
`endif

endmodule

// ----- hw/rtl/gemp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gemp_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
